/* hw/rtl/rtt_pkg.sv */
// Shared types, constants, digit tables and decode functions for the radix text parser.
`timescale 1ns / 1ps

package rtt_pkg;

   // Field widths
   localparam int CharWidth  = 8;
   localparam int ValueWidth = 64;
   localparam int RadixWidth = 7;
   localparam int DigitWidth = 8;

   // Radix codes and character codes
   localparam logic [RadixWidth-1:0] RADIX_RESET = 7'd10;
   localparam logic [RadixWidth-1:0] RADIX_DEC   = 7'd10;
   localparam logic [RadixWidth-1:0] RADIX_HEX   = 7'd16;
   localparam logic [RadixWidth-1:0] RADIX_B32   = 7'd32;
   localparam logic [RadixWidth-1:0] RADIX_B64   = 7'd64;
   localparam logic [RadixWidth-1:0] RADIX_MIN   = 7'd2;

   localparam logic [CharWidth-1:0] CHAR_END      = 8'h00;
   localparam logic [CharWidth-1:0] CHAR_TAB      = 8'h09;
   localparam logic [CharWidth-1:0] CHAR_CR       = 8'h0D;
   localparam logic [CharWidth-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CharWidth-1:0] CHAR_MINUS    = 8'h2D;
   localparam logic [CharWidth-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_NINE     = 8'h39;
   localparam logic [CharWidth-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [CharWidth-1:0] CHAR_UPPER_F  = 8'h46;
   localparam logic [CharWidth-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_LOWER_F  = 8'h66;
   localparam logic [CharWidth-1:0] CHAR_LOWER_X  = 8'h78;
   localparam logic [CharWidth-1:0] TABLE_BASE    = 8'h20;
   localparam logic [CharWidth-1:0] TABLE_END     = 8'h80;

   localparam logic [DigitWidth-1:0] NO_DIG  = 8'hFF;
   localparam logic [DigitWidth-1:0] DIG_TEN = 8'd10;

   localparam int TableDepth = 96;

   // Base 32 digit values for bytes 0x20 to 0x7F
   localparam logic [DigitWidth-1:0] TAB32 [TableDepth] = '{
      NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      8'd14, 8'd11, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
      NO_DIG, 8'd6, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      NO_DIG, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
      8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
      8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
      8'd23, 8'd24, 8'd25, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      NO_DIG, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
      8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
      8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
      8'd23, 8'd24, 8'd25, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG
   };

   // Base 64 digit values for bytes 0x20 to 0x7F
   localparam logic [DigitWidth-1:0] TAB64 [TableDepth] = '{
      NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      NO_DIG, NO_DIG, NO_DIG, 8'd62, NO_DIG, 8'd62, NO_DIG, 8'd63,
      8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
      8'd60, 8'd61, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG,
      NO_DIG, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
      8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
      8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
      8'd23, 8'd24, 8'd25, NO_DIG, NO_DIG, NO_DIG, NO_DIG, 8'd63,
      NO_DIG, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32,
      8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
      8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48,
      8'd49, 8'd50, 8'd51, NO_DIG, NO_DIG, NO_DIG, NO_DIG, NO_DIG
   };

   // Parser phase
   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   // Classification of one character under the current radix
   typedef struct packed {
      logic                  is_space;
      logic [DigitWidth-1:0] digit;
   } char_class_type;

   // Result of one string
   typedef struct packed {
      logic [ValueWidth-1:0] value;
      logic                  invalid;
   } result_type;

   // Whitespace is tab to carriage return, and space.
   function automatic logic is_space(input logic [CharWidth-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic radix_ok(input logic [RadixWidth-1:0] r);
      return ((r >= RADIX_MIN) && (r <= RADIX_HEX)) || (r == RADIX_B32) || (r == RADIX_B64);
   endfunction

   // Digit value of a character; NO_DIG where the character has none.
   function automatic logic [DigitWidth-1:0] digit_of(input logic [CharWidth-1:0] c,
                                                     input logic [RadixWidth-1:0] r);
      logic [6:0]            ix;
      logic [DigitWidth-1:0] d;
      ix = 7'(c - TABLE_BASE);
      d  = NO_DIG;
      if ((r == RADIX_B32) || (r == RADIX_B64)) begin
         if ((c > TABLE_BASE) && (c < TABLE_END)) begin
            d = (r == RADIX_B32) ? TAB32[ix] : TAB64[ix];
         end
      end else if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
         d = c - CHAR_ZERO;
      end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         d = c - CHAR_LOWER_A + DIG_TEN;
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         d = c - CHAR_UPPER_A + DIG_TEN;
      end
      return d;
   endfunction

endpackage

/* hw/rtl/rtt_if.sv */
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps

interface rtt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface rtt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] value;
   logic               invalid;

   modport source (output valid, output value, output invalid, input ready);
   modport sink (input valid, input value, input invalid, output ready);
endinterface

/* hw/rtl/rtt_char_decode.sv */
// Character classifier: whitespace flag and digit value under the active radix.
`timescale 1ns / 1ps

module rtt_char_decode (
   input  logic [rtt_pkg::CharWidth-1:0]  char_code,
   input  logic [rtt_pkg::RadixWidth-1:0] radix,
   output rtt_pkg::char_class_type        char_class
);

   // Table lookup for bases 32 and 64, hex digit values otherwise.
   always_comb begin
      char_class.is_space = rtt_pkg::is_space(char_code);
      char_class.digit    = rtt_pkg::digit_of(char_code, radix);
   end

endmodule

/* hw/rtl/rtt_parse_core.sv */
// Parser state: phase machine, sign, sticky error, active radix and the accumulator.
`timescale 1ns / 1ps

module rtt_parse_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rtt_pkg::RadixWidth-1:0]    csr_wr_data,
   input  logic                              step_fire,
   input  logic [rtt_pkg::CharWidth-1:0]     step_char,
   output rtt_pkg::result_type               result
);

   localparam int ProdWidth = rtt_pkg::ValueWidth + rtt_pkg::RadixWidth;

   rtt_pkg::phase_type                  phase_ff, phase_in;
   logic [rtt_pkg::ValueWidth-1:0]      acc_ff, acc_in;
   logic                                neg_ff, neg_in;
   logic                                err_ff, err_in;
   logic [rtt_pkg::RadixWidth-1:0]      eff_ff, eff_in;
   logic [rtt_pkg::RadixWidth-1:0]      radix_ff, radix_in;

   rtt_pkg::char_class_type             char_class;
   logic                                is_term;
   logic                                is_minus;
   logic                                is_zero;
   logic                                is_x;
   logic                                is_dec;
   logic                                take_digit;
   logic                                set_neg;
   logic                                set_hex;
   logic                                digit_bad;
   logic [ProdWidth-1:0]                prod;
   logic                                bad;

   rtt_char_decode u_decode (
      .char_code  (step_char),
      .radix      (eff_ff),
      .char_class (char_class)
   );

   // Character classes used by the phase machine
   assign is_term  = (step_char == rtt_pkg::CHAR_END);
   assign is_minus = (step_char == rtt_pkg::CHAR_MINUS);
   assign is_zero  = (step_char == rtt_pkg::CHAR_ZERO);
   assign is_x     = (step_char == rtt_pkg::CHAR_LOWER_X);
   assign is_dec   = (eff_ff == rtt_pkg::RADIX_DEC);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step_fire) begin
         if (is_term) begin
            phase_in = rtt_pkg::PH_SPACE;
         end else begin
            unique case (phase_ff)
               rtt_pkg::PH_SPACE: begin
                  if (!char_class.is_space) begin
                     if (!is_dec) begin
                        phase_in = rtt_pkg::PH_DIGITS;
                     end else if (is_minus) begin
                        phase_in = rtt_pkg::PH_SIGNED;
                     end else if (is_zero) begin
                        phase_in = rtt_pkg::PH_ZERO;
                     end else begin
                        phase_in = rtt_pkg::PH_DIGITS;
                     end
                  end
               end
               rtt_pkg::PH_SIGNED: begin
                  phase_in = is_zero ? rtt_pkg::PH_ZERO : rtt_pkg::PH_DIGITS;
               end
               rtt_pkg::PH_ZERO:   phase_in = rtt_pkg::PH_DIGITS;
               rtt_pkg::PH_DIGITS: phase_in = rtt_pkg::PH_DIGITS;
               default:            phase_in = rtt_pkg::PH_SPACE;
            endcase
         end
      end
   end

   // Actions that the phase machine asks for on this character
   always_comb begin
      take_digit = 1'b0;
      set_neg    = 1'b0;
      set_hex    = 1'b0;
      if (step_fire && !is_term) begin
         unique case (phase_ff)
            rtt_pkg::PH_SPACE: begin
               take_digit = !char_class.is_space && (!is_dec || (!is_minus && !is_zero));
               set_neg    = !char_class.is_space && is_dec && is_minus;
            end
            rtt_pkg::PH_SIGNED: take_digit = !is_zero;
            rtt_pkg::PH_ZERO: begin
               take_digit = !is_x;
               set_hex    = is_x;
            end
            rtt_pkg::PH_DIGITS: take_digit = 1'b1;
            default:            take_digit = 1'b0;
         endcase
      end
   end

   // One multiply-add step of the accumulator
   assign prod      = ProdWidth'(acc_ff) * ProdWidth'(eff_ff);
   assign digit_bad = (char_class.digit >= rtt_pkg::DigitWidth'(eff_ff));

   always_comb begin
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      err_in   = err_ff;
      eff_in   = eff_ff;
      radix_in = radix_ff;
      if (step_fire && is_term) begin
         acc_in = '0;
         neg_in = 1'b0;
         err_in = 1'b0;
         eff_in = radix_ff;
      end else begin
         if (take_digit && !err_ff) begin
            if (digit_bad) begin
               err_in = 1'b1;
            end else begin
               acc_in = prod[rtt_pkg::ValueWidth-1:0]
                        + rtt_pkg::ValueWidth'(char_class.digit);
            end
         end
         if (set_neg) begin
            neg_in = 1'b1;
         end
         if (set_hex) begin
            eff_in = rtt_pkg::RADIX_HEX;
         end
      end
      // A radix write reaches the active radix while only whitespace has been seen.
      if (csr_wr_en) begin
         radix_in = csr_wr_data;
         if (phase_ff == rtt_pkg::PH_SPACE) begin
            eff_in = csr_wr_data;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rtt_pkg::PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         err_ff   <= 1'b0;
         eff_ff   <= rtt_pkg::RADIX_RESET;
         radix_ff <= rtt_pkg::RADIX_RESET;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         err_ff   <= err_in;
         eff_ff   <= eff_in;
         radix_ff <= radix_in;
      end
   end

   // Final value for a terminating character: negated if signed, zero if invalid.
   assign bad = err_ff || !rtt_pkg::radix_ok(eff_ff);

   always_comb begin
      result.invalid = bad;
      if (bad) begin
         result.value = '0;
      end else if (neg_ff) begin
         result.value = '0 - acc_ff;
      end else begin
         result.value = acc_ff;
      end
   end

endmodule

/* hw/rtl/radix_text_to_int64_parser.sv */
// Top level of the radix text to 64-bit integer parser.
`timescale 1ns / 1ps
// Usage
//   req_chan carries one character byte per transaction. A zero byte ends the
//   string and produces exactly one transaction on rsp_chan with the 64-bit
//   two's complement value and the invalid flag; other bytes produce none.
//   csr_wr_en/csr_wr_data write the 7-bit radix register (reset value 10).
//   Write it only between strings, or while only whitespace has been sent.
// Throughput and pipeline
//   One character is taken every cycle unless a zero byte waits for a
//   stalled output register. Each character passes an input register, then
//   one multiply-add of the accumulator by the radix (a 64 by 7 bit product)
//   updates the parser state. A string's result is registered for rsp_chan.
// Stalls
//   If rsp_chan is stalled, the pending result is held in the output
//   register and further non-zero characters are still taken; a following
//   zero byte waits in the input register until the result is taken.
// Reset
//   Reset clears all parser state, sets the radix to 10 and empties both
//   registers, so no result is pending afterwards.

module radix_text_to_int64_parser (
   input  logic                           clock,
   input  logic                           reset,
   rtt_req_if.sink                        req_chan,
   rtt_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [rtt_pkg::RadixWidth-1:0] csr_wr_data
);

   logic                          in_valid_ff, in_valid_in;
   logic [rtt_pkg::CharWidth-1:0] in_char_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   rtt_pkg::result_type           rsp_data_ff;
   rtt_pkg::result_type           result;
   logic                          in_is_term;
   logic                          fire;
   logic                          load_rsp;

   // A zero byte proceeds only when the output register is empty or being read.
   assign in_is_term = (in_char_ff == rtt_pkg::CHAR_END);
   assign fire       = in_valid_ff && (!in_is_term || !rsp_valid_ff || rsp_chan.ready);
   assign load_rsp   = fire && in_is_term;
   assign req_chan.ready = !in_valid_ff || fire;

   rtt_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_fire   (fire),
      .step_char   (in_char_ff),
      .result      (result)
   );

   // Input register
   assign in_valid_in = req_chan.valid || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_char_ff <= req_chan.char_code;
      end
   end

   // Output register
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.value   = $signed(rsp_data_ff.value);
   assign rsp_chan.invalid = rsp_data_ff.invalid;

endmodule

/* hw/rtl/rtt_checker.sv */
// Port-level assertions for the radix text parser, bound to its top level.
`timescale 1ns / 1ps

module rtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_invalid
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_invalid))
   else $error("rtt: stalled result changed");

   // An invalid result always carries the value zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_value == 64'd0)
   else $error("rtt: invalid result with non-zero value");

   // Input back-pressure only comes from a stalled, full output register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
   else $error("rtt: input stalled without output stall");

   // Reset leaves no pending result and an open input.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
   else $error("rtt: block not empty after reset");

endmodule

bind radix_text_to_int64_parser rtt_checker u_rtt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_value   (rsp_chan.value),
   .rsp_invalid (rsp_chan.invalid)
);

/* tb/sv/radix_text_to_int64_parser_tb.sv */
// Self-checking testbench for the radix text to 64-bit integer parser.
`timescale 1ns / 1ps

module radix_text_to_int64_parser_tb;

   // Characters that the package does not name
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_PLUS       = 8'h2B;
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_SLASH      = 8'h2F;
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_DEL        = 8'h7F;
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_HIGH       = 8'h80;
   localparam logic [rtt_pkg::CharWidth-1:0] CHAR_MAX        = 8'hFF;

   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 140;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [rtt_pkg::RadixWidth-1:0] csr_wr_data;

   rtt_req_if req_chan ();
   rtt_rsp_if rsp_chan ();

   radix_text_to_int64_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the parser state and its radix register.
   logic [rtt_pkg::RadixWidth-1:0] radix_reg;
   logic [rtt_pkg::RadixWidth-1:0] active_radix;
   logic [rtt_pkg::ValueWidth-1:0] acc_value;
   rtt_pkg::phase_type             parse_phase;
   logic                           minus_seen;
   logic                           bad_seen;

   rtt_pkg::result_type           pending_results [$];
   logic [rtt_pkg::CharWidth-1:0] text_buf [$];

   int  fail_count    = 0;
   int  checked_count = 0;
   int  string_count  = 0;
   int  char_count    = 0;
   int  cycle_count   = 0;
   int  stall_left    = 0;
   bit  idle_on       = 1'b1;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver back-pressure in short random bursts.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && ($urandom_range(0, 4) == 0)) begin
         stall_left <= $urandom_range(0, 3);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare every result transaction with the oldest prediction.
   always @(posedge clock) begin : result_check
      rtt_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: value %0d invalid %0b",
                   rsp_chan.value, rsp_chan.invalid);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.value !== want.value) begin
               $error("value mismatch: expected %0d, actual %0d",
                      $signed(want.value), rsp_chan.value);
               fail_count++;
            end
            if (rsp_chan.invalid !== want.invalid) begin
               $error("invalid mismatch: expected %0b, actual %0b",
                      want.invalid, rsp_chan.invalid);
               fail_count++;
            end
            checked_count++;
         end
      end
   end

   function automatic logic is_blank(input logic [rtt_pkg::CharWidth-1:0] c);
      return (c == rtt_pkg::CHAR_SPACE) ||
             ((c >= rtt_pkg::CHAR_TAB) && (c <= rtt_pkg::CHAR_CR));
   endfunction

   function automatic logic radix_valid(input logic [rtt_pkg::RadixWidth-1:0] r);
      return ((r >= rtt_pkg::RADIX_MIN) && (r <= rtt_pkg::RADIX_HEX)) ||
             (r == rtt_pkg::RADIX_B32) || (r == rtt_pkg::RADIX_B64);
   endfunction

   // Digit value of a byte under a given radix, NO_DIG where it has none.
   function automatic logic [rtt_pkg::DigitWidth-1:0] char_digit(
      input logic [rtt_pkg::CharWidth-1:0]  c,
      input logic [rtt_pkg::RadixWidth-1:0] r);
      logic [rtt_pkg::DigitWidth-1:0] d;
      d = rtt_pkg::NO_DIG;
      if (r == rtt_pkg::RADIX_B32) begin
         if ((c >= "A") && (c <= "Z")) d = c - "A";
         else if ((c >= "a") && (c <= "z")) d = c - "a";
         else if ((c >= "2") && (c <= "7")) d = c - "2" + 8'd26;
         else if (c == "0") d = 8'd14;
         else if (c == "1") d = 8'd11;
         else if (c == "9") d = 8'd6;
      end else if (r == rtt_pkg::RADIX_B64) begin
         if ((c >= "A") && (c <= "Z")) d = c - "A";
         else if ((c >= "a") && (c <= "z")) d = c - "a" + 8'd26;
         else if ((c >= "0") && (c <= "9")) d = c - "0" + 8'd52;
         else if ((c == CHAR_PLUS) || (c == rtt_pkg::CHAR_MINUS)) d = 8'd62;
         else if ((c == CHAR_SLASH) || (c == CHAR_UNDERSCORE)) d = 8'd63;
      end else begin
         if ((c >= "0") && (c <= "9")) d = c - "0";
         else if ((c >= "a") && (c <= "f")) d = c - "a" + 8'd10;
         else if ((c >= "A") && (c <= "F")) d = c - "A" + 8'd10;
      end
      return d;
   endfunction

   task automatic restart_parse();
      acc_value    = '0;
      parse_phase  = rtt_pkg::PH_SPACE;
      minus_seen   = 1'b0;
      bad_seen     = 1'b0;
      active_radix = radix_reg;
   endtask

   // One digit step; the error is sticky and freezes the accumulator.
   task automatic add_digit(input logic [rtt_pkg::CharWidth-1:0] c);
      logic [rtt_pkg::DigitWidth-1:0] d;
      d = char_digit(c, active_radix);
      parse_phase = rtt_pkg::PH_DIGITS;
      if (!bad_seen) begin
         if (d >= {1'b0, active_radix}) begin
            bad_seen = 1'b1;
         end else begin
            acc_value = acc_value * 64'(active_radix) + 64'(d);
         end
      end
   endtask

   // Advance the shadow parser by one accepted byte.
   task automatic parse_char(input logic [rtt_pkg::CharWidth-1:0] c);
      rtt_pkg::result_type res;
      logic                bad;
      if (c == rtt_pkg::CHAR_END) begin
         bad         = bad_seen || !radix_valid(active_radix);
         res.value   = bad ? '0 : (minus_seen ? -acc_value : acc_value);
         res.invalid = bad;
         pending_results.push_back(res);
         string_count++;
         restart_parse();
      end else begin
         case (parse_phase)
            rtt_pkg::PH_SPACE: begin
               if (!is_blank(c)) begin
                  if (active_radix != rtt_pkg::RADIX_DEC) begin
                     add_digit(c);
                  end else if (c == rtt_pkg::CHAR_MINUS) begin
                     minus_seen  = 1'b1;
                     parse_phase = rtt_pkg::PH_SIGNED;
                  end else if (c == rtt_pkg::CHAR_ZERO) begin
                     parse_phase = rtt_pkg::PH_ZERO;
                  end else begin
                     add_digit(c);
                  end
               end
            end
            rtt_pkg::PH_SIGNED: begin
               if (c == rtt_pkg::CHAR_ZERO) parse_phase = rtt_pkg::PH_ZERO;
               else add_digit(c);
            end
            rtt_pkg::PH_ZERO: begin
               if (c == rtt_pkg::CHAR_LOWER_X) begin
                  active_radix = rtt_pkg::RADIX_HEX;
                  parse_phase  = rtt_pkg::PH_DIGITS;
               end else begin
                  add_digit(c);
               end
            end
            default: add_digit(c);
         endcase
      end
   endtask

   // Send one byte, with an occasional idle burst before it.
   task automatic send_char(input logic [rtt_pkg::CharWidth-1:0] c);
      if (idle_on && ($urandom_range(0, 4) == 0)) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= c;
      do @(posedge clock); while (!req_chan.ready);
      parse_char(c);
      char_count++;
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i]);
   endtask

   // Stop sending, wait for all results, then let the pipeline empty.
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Radix write on an idle block.
   task automatic write_radix(input logic [rtt_pkg::RadixWidth-1:0] r);
      settle_block();
      csr_wr_data <= r;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      radix_reg = r;
      if (parse_phase == rtt_pkg::PH_SPACE) active_radix = r;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [rtt_pkg::CharWidth-1:0] pick_blank();
      int b;
      b = $urandom_range(0, 5);
      return (b == 5) ? rtt_pkg::CHAR_SPACE : rtt_pkg::CHAR_TAB + 8'(b);
   endfunction

   // A byte that is a legal digit of the radix; a hex digit for bad radices.
   function automatic logic [rtt_pkg::CharWidth-1:0] pick_digit(
      input logic [rtt_pkg::RadixWidth-1:0] r);
      logic [rtt_pkg::CharWidth-1:0] c;
      int                            d;
      if ((r >= rtt_pkg::RADIX_MIN) && (r <= rtt_pkg::RADIX_HEX)) begin
         d = $urandom_range(0, int'(r) - 1);
         if (d < 10) return rtt_pkg::CHAR_ZERO + 8'(d);
         c = $urandom_range(0, 1) ? rtt_pkg::CHAR_LOWER_A : rtt_pkg::CHAR_UPPER_A;
         return c + 8'(d - 10);
      end
      if ((r == rtt_pkg::RADIX_B32) || (r == rtt_pkg::RADIX_B64)) begin
         do c = 8'($urandom_range(33, 127)); while (char_digit(c, r) == rtt_pkg::NO_DIG);
         return c;
      end
      return pick_digit(rtt_pkg::RADIX_HEX);
   endfunction

   // Build one random string: mostly well formed, some broken, some noise.
   task automatic compose_text();
      int                             kind;
      int                             n;
      logic [rtt_pkg::RadixWidth-1:0] dr;
      text_buf.delete();
      kind = $urandom_range(0, 99);
      dr   = radix_reg;
      repeat ($urandom_range(0, 2)) text_buf.push_back(pick_blank());
      if (kind < 92) begin
         if (dr == rtt_pkg::RADIX_DEC) begin
            if ($urandom_range(0, 2) == 0) text_buf.push_back(rtt_pkg::CHAR_MINUS);
            if ($urandom_range(0, 3) == 0) begin
               text_buf.push_back(rtt_pkg::CHAR_ZERO);
               text_buf.push_back(rtt_pkg::CHAR_LOWER_X);
               dr = rtt_pkg::RADIX_HEX;
            end else if ($urandom_range(0, 5) == 0) begin
               text_buf.push_back(rtt_pkg::CHAR_ZERO);
            end
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
         repeat (n) text_buf.push_back(pick_digit(dr));
         // Broken strings carry one stray byte somewhere.
         if (kind >= 80) begin
            text_buf.insert($urandom_range(0, text_buf.size()), 8'($urandom_range(1, 255)));
         end
      end else begin
         repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      text_buf.push_back(rtt_pkg::CHAR_END);
   endtask

   // Decimal forms: empty, whitespace and sign, 0x prefix, bad characters.
   task automatic test_decimal_forms();
      text_buf = '{rtt_pkg::CHAR_END,
                   rtt_pkg::CHAR_SPACE, rtt_pkg::CHAR_TAB, rtt_pkg::CHAR_MINUS, "1", "2",
                   rtt_pkg::CHAR_END,
                   rtt_pkg::CHAR_ZERO, rtt_pkg::CHAR_LOWER_X, rtt_pkg::CHAR_END,
                   rtt_pkg::CHAR_ZERO, rtt_pkg::CHAR_END,
                   rtt_pkg::CHAR_MINUS, rtt_pkg::CHAR_ZERO, rtt_pkg::CHAR_LOWER_X, "F", "f",
                   rtt_pkg::CHAR_END,
                   "7", rtt_pkg::CHAR_SPACE, CHAR_MAX, CHAR_HIGH, rtt_pkg::CHAR_END};
      send_text();
   endtask

   // The two table bases, with their extra symbols and a byte with no entry.
   task automatic test_table_radices();
      write_radix(rtt_pkg::RADIX_B64);
      text_buf = '{CHAR_PLUS, rtt_pkg::CHAR_MINUS, CHAR_SLASH, CHAR_UNDERSCORE, "9",
                   rtt_pkg::CHAR_END,
                   "A", CHAR_DEL, rtt_pkg::CHAR_END};
      send_text();
      write_radix(rtt_pkg::RADIX_B32);
      text_buf = '{"0", "1", "9", "z", rtt_pkg::CHAR_END, "8", rtt_pkg::CHAR_END};
      send_text();
   endtask

   // Radix writes inside a string, before and after its first digit.
   task automatic test_radix_write_timing();
      write_radix(rtt_pkg::RADIX_DEC);
      text_buf = '{rtt_pkg::CHAR_SPACE};
      send_text();
      write_radix(rtt_pkg::RADIX_HEX);
      text_buf = '{"f", rtt_pkg::CHAR_END, "1"};
      send_text();
      write_radix(rtt_pkg::RADIX_DEC);
      text_buf = '{"a", rtt_pkg::CHAR_END};
      send_text();
   endtask

   // Random strings under one radix setting.
   task automatic test_random_radix(input logic [rtt_pkg::RadixWidth-1:0] r,
                                    input int count);
      int stop;
      write_radix(r);
      stop = char_count + count;
      while (char_count < stop) begin
         compose_text();
         send_text();
         if ($urandom_range(0, 24) == 0) settle_block();
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      rsp_chan.ready     = 1'b0;
      radix_reg          = rtt_pkg::RADIX_RESET;
      restart_parse();

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_decimal_forms();
      test_table_radices();
      test_radix_write_timing();

      test_random_radix(rtt_pkg::RADIX_DEC, PHASE_ITEMS);
      test_random_radix(rtt_pkg::RADIX_MIN, PHASE_ITEMS);
      test_random_radix(rtt_pkg::RADIX_HEX, PHASE_ITEMS);
      test_random_radix(rtt_pkg::RADIX_B32, PHASE_ITEMS);
      test_random_radix(rtt_pkg::RADIX_B64, PHASE_ITEMS);
      test_random_radix(7'd0, PHASE_ITEMS);
      test_random_radix(7'd127, PHASE_ITEMS);
      test_random_radix(7'($urandom_range(0, 127)), PHASE_ITEMS);
      // Last stretch runs at full rate on both sides.
      idle_on = 1'b0;
      test_random_radix(rtt_pkg::RADIX_DEC, PHASE_ITEMS);

      settle_block();
      repeat (8) @(posedge clock);

      $display("Sent %0d strings in %0d characters and checked %0d results,",
               string_count, char_count, checked_count);
      $display("across radix settings from 0 to 127 including every table and hex base.");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
